### src/gbc_pkg.sv
// ----------------------------------------------------------------------------
// gbc_pkg
// Types, constants and helpers shared by the gyro bias calibration block.
// ----------------------------------------------------------------------------
package gbc_pkg;

  localparam int MAX_AXES  = 3;
  localparam int LEN_W     = 16;
  localparam int THR_W     = 10;
  localparam int SUM_W     = 32;
  localparam int SQ_W      = 48;
  localparam int LIM_W     = 52;
  localparam int QUO_W     = 32;
  localparam int DIV_CNT_W = 5;

  localparam logic [LEN_W-1:0] LEN_RESET = 16'd1000;
  localparam logic [THR_W-1:0] THR_RESET = 10'd32;

  typedef logic signed [15:0] gbc_word_t;

  typedef enum logic [0:0] {
    REG_LEN = 1'b0,
    REG_THR = 1'b1
  } gbc_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUB,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } gbc_state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic mul;
    logic sub;
    logic div_start;
    logic div_step;
    logic sums_clear;
  } gbc_lane_ctrl_t;

  typedef struct packed {
    logic             over;
    logic             neg;
    logic [QUO_W-1:0] quo;
  } gbc_lane_stat_t;

  typedef struct packed {
    gbc_word_t [MAX_AXES-1:0] bias;
    logic                     restarted;
    logic                     calibrating;
    gbc_word_t [MAX_AXES-1:0] rate;
  } gbc_result_t;

  function automatic gbc_word_t sat_diff(input gbc_word_t a, input gbc_word_t b);
    logic signed [16:0] d;
    d = 17'(a) - 17'(b);
    if (d > 17'sd32767) begin
      return 16'sh7fff;
    end else if (d < -17'sd32768) begin
      return 16'sh8000;
    end else begin
      return gbc_word_t'(d[15:0]);
    end
  endfunction

endpackage

### src/gbc_lane.sv
// ----------------------------------------------------------------------------
// gbc_lane
// One axis: running sums, spread products for the stillness test and a
// radix-2 restoring divider for the bias.
// ----------------------------------------------------------------------------
module gbc_lane (
  input  logic                  clk,
  input  gbc_pkg::gbc_lane_ctrl_t ctrl,
  input  gbc_pkg::gbc_word_t    smp,
  input  logic [15:0]           n,
  input  logic [51:0]           lim,
  output gbc_pkg::gbc_lane_stat_t stat
);
  import gbc_pkg::*;

  logic signed [SUM_W-1:0] sum;
  logic [SQ_W-1:0]         sq;
  logic signed [31:0]      smp_sq;
  logic [31:0]             sum_abs;
  logic [39:0]             nsq_hi;
  logic [39:0]             nsq_lo;
  logic [61:0]             s1sq;
  logic [63:0]             nsq;
  logic signed [63:0]      spread;
  logic [32:0]             dividend;
  logic [32:0]             dividend_abs;
  logic [QUO_W-1:0]        dvd;
  logic [15:0]             rem;
  logic [16:0]             trial;
  logic                    neg;

  assign smp_sq       = 32'(smp) * 32'(smp);
  assign sum_abs      = sum[SUM_W-1] ? 32'(-sum) : 32'(sum);
  assign nsq          = {nsq_hi, 24'b0} + {24'b0, nsq_lo};
  assign dividend     = {sum[SUM_W-1], sum} + {18'b0, n[15:1]};
  assign dividend_abs = dividend[32] ? -dividend : dividend;
  assign trial        = {rem, dvd[QUO_W-1]};

  // accumulation
  always_ff @(posedge clk) begin
    if (ctrl.sums_clear) begin
      sum <= '0;
      sq  <= '0;
    end else if (ctrl.load) begin
      sum <= (ctrl.clear ? '0 : sum) + 32'(smp);
      sq  <= (ctrl.clear ? '0 : sq) + {16'b0, smp_sq};
    end
  end

  // spread n*S2 - S1*S1
  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      nsq_hi <= 40'(n) * 40'(sq[47:24]);
      nsq_lo <= 40'(n) * 40'(sq[23:0]);
      s1sq   <= 62'(sum_abs[30:0]) * 62'(sum_abs[30:0]);
    end
    if (ctrl.sub) begin
      spread <= signed'(nsq) - signed'({2'b0, s1sq});
    end
  end

  // bias division, magnitude first, sign restored in the merge
  always_ff @(posedge clk) begin
    if (ctrl.div_start) begin
      dvd <= dividend_abs[QUO_W-1:0];
      rem <= '0;
      neg <= dividend[32];
    end else if (ctrl.div_step) begin
      if (trial >= {1'b0, n}) begin
        rem <= 16'(trial - {1'b0, n});
        dvd <= {dvd[QUO_W-2:0], 1'b1};
      end else begin
        rem <= trial[15:0];
        dvd <= {dvd[QUO_W-2:0], 1'b0};
      end
    end
  end

  assign stat.over = spread > signed'({12'b0, lim});
  assign stat.neg  = neg;
  assign stat.quo  = dvd;

endmodule

### src/gbc_merge.sv
// ----------------------------------------------------------------------------
// gbc_merge
// Combines the lane results: stillness verdict and saturated biases.
// ----------------------------------------------------------------------------
module gbc_merge #(
  parameter int AXES = 3
) (
  input  gbc_pkg::gbc_lane_stat_t lane_stat [AXES],
  input  logic                    thr_en,
  output logic                    moved,
  output gbc_pkg::gbc_word_t      bias [gbc_pkg::MAX_AXES]
);
  import gbc_pkg::*;

  always_comb begin
    moved = 1'b0;
    for (int a = 0; a < MAX_AXES; a++) begin
      bias[a] = '0;
      if (a < AXES) begin
        moved = moved | lane_stat[a].over;
        if (!lane_stat[a].neg) begin
          bias[a] = (lane_stat[a].quo > 32'd32767) ? 16'sh7fff
                                                    : gbc_word_t'(lane_stat[a].quo[15:0]);
        end else begin
          bias[a] = (lane_stat[a].quo > 32'd32768) ? 16'sh8000
                                                    : gbc_word_t'(-lane_stat[a].quo[15:0]);
        end
      end
    end
    moved = moved & thr_en;
  end

endmodule

### src/gyro_bias_calibration_still_check_top.sv
// ----------------------------------------------------------------------------
// gyro_bias_calibration_still_check_top
// Gyro bias calibration with a per-axis stillness check.
// ----------------------------------------------------------------------------
// Each transfer carries one three-axis gyro sample. Setting the start flag
// begins a calibration run of calibration_length samples; while a run is
// collecting, rates read 0 and calibrating is set. On the last sample every
// axis is tested against a nonzero stillness threshold; a failed test sets
// restarted and begins a fresh run, a pass loads the rounded mean as the new
// bias. Outside a run the rates are the samples minus the bias, saturated.
// A sample that does not end a run leaves the sequencer idle. The sample that
// ends a run holds the input through the spread products (MUL, SUB), the test
// (CHECK), the one-bit-per-cycle bias divider in each lane (DIV) and DONE,
// which posts the result; a failed run releases after CHECK. A result waiting
// in the output register does not block the next input; one in the skid does.
// ----------------------------------------------------------------------------
module gyro_bias_calibration_still_check_top #(
  parameter int AXES = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // gyro_x, gyro_y, gyro_z
  input  logic [0:0]  s_tuser,   // start_calibration
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // rate_x, rate_y, rate_z, bias_x, bias_y, bias_z
  output logic [1:0]  m_tuser,   // calibrating, restarted
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import gbc_pkg::*;

  gbc_state_t             state;
  gbc_state_t             state_next;
  logic [LEN_W-1:0]       cfg_len;
  logic [THR_W-1:0]       cfg_thr;
  logic [LEN_W-1:0]       samples_left;
  gbc_word_t              bias_value [MAX_AXES];
  logic [19:0]            thr_sq;
  logic [31:0]            nn;
  logic [LIM_W-1:0]       lim;
  logic [DIV_CNT_W-1:0]   div_cnt;
  gbc_result_t            out_res;
  gbc_result_t            skid_res;
  logic                   skid_valid;

  logic [LEN_W-1:0]       n_eff;
  logic                   in_xfer;
  logic                   start;
  gbc_word_t              smp [MAX_AXES];
  logic [LEN_W-1:0]       left_eff;
  logic                   cal_now;
  logic                   last_now;
  gbc_lane_ctrl_t         lane_ctrl;
  gbc_lane_stat_t         lane_stat [AXES];
  logic                   moved;
  gbc_word_t              merged_bias [MAX_AXES];
  logic                   push;
  gbc_result_t            res;

  assign n_eff     = (cfg_len == '0) ? 16'd1 : cfg_len;
  assign s_tready  = (state == ST_IDLE) && !skid_valid;
  assign cfg_ready = 1'b1;
  assign in_xfer   = s_tvalid && s_tready;
  assign start     = s_tuser[0];
  assign left_eff  = start ? n_eff : samples_left;
  assign cal_now   = left_eff != '0;
  assign last_now  = left_eff == 16'd1;

  always_comb begin
    for (int a = 0; a < MAX_AXES; a++) begin
      smp[a] = (a < AXES) ? gbc_word_t'(s_tdata[16*a +: 16]) : '0;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_len <= LEN_RESET;
      cfg_thr <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (gbc_reg_t'(cfg_index))
        REG_LEN: cfg_len <= cfg_data;
        REG_THR: cfg_thr <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // lanes
  for (genvar g = 0; g < AXES; g++) begin : g_lane
    gbc_lane u_lane (
      .clk  (clk),
      .ctrl (lane_ctrl),
      .smp  (smp[g]),
      .n    (n_eff),
      .lim  (lim),
      .stat (lane_stat[g])
    );
  end

  gbc_merge #(
    .AXES (AXES)
  ) u_merge (
    .lane_stat (lane_stat),
    .thr_en    (cfg_thr != '0),
    .moved     (moved),
    .bias      (merged_bias)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_xfer && last_now) state_next = ST_MUL;
      ST_MUL:   state_next = ST_SUB;
      ST_SUB:   state_next = ST_CHECK;
      ST_CHECK: state_next = moved ? ST_IDLE : ST_DIV;
      ST_DIV:   if (div_cnt == '1) state_next = ST_DONE;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    lane_ctrl       = '0;
    push            = 1'b0;
    res.calibrating = 1'b0;
    res.restarted   = 1'b0;
    for (int a = 0; a < MAX_AXES; a++) begin
      res.rate[a] = '0;
      res.bias[a] = '0;
    end
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          lane_ctrl.load  = cal_now;
          lane_ctrl.clear = start;
          push            = !last_now;
          res.calibrating = cal_now;
          for (int a = 0; a < MAX_AXES; a++) begin
            if (!cal_now && a < AXES) begin
              res.rate[a] = sat_diff(smp[a], bias_value[a]);
              res.bias[a] = bias_value[a];
            end
          end
        end
      end
      ST_MUL: lane_ctrl.mul = 1'b1;
      ST_SUB: lane_ctrl.sub = 1'b1;
      ST_CHECK: begin
        if (moved) begin
          lane_ctrl.sums_clear = 1'b1;
          push                 = 1'b1;
          res.calibrating      = 1'b1;
          res.restarted        = 1'b1;
        end else begin
          lane_ctrl.div_start = 1'b1;
        end
      end
      ST_DIV: lane_ctrl.div_step = 1'b1;
      ST_DONE: begin
        push            = 1'b1;
        res.calibrating = 1'b1;
        for (int a = 0; a < MAX_AXES; a++) begin
          res.bias[a] = merged_bias[a];
        end
      end
      default: ;
    endcase
  end

  // sequencer and run state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      samples_left <= '0;
      for (int a = 0; a < MAX_AXES; a++) begin
        bias_value[a] <= '0;
      end
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (in_xfer && cal_now) begin
            samples_left <= last_now ? left_eff : left_eff - 16'd1;
            for (int a = 0; a < MAX_AXES; a++) begin
              bias_value[a] <= '0;
            end
          end
        end
        ST_CHECK: if (moved) samples_left <= n_eff;
        ST_DONE: begin
          samples_left <= '0;
          for (int a = 0; a < MAX_AXES; a++) begin
            bias_value[a] <= merged_bias[a];
          end
        end
        default: ;
      endcase
    end
  end

  // test limit thr^2 * n * (n - 1) and divider step count
  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      thr_sq <= 20'(cfg_thr) * 20'(cfg_thr);
      nn     <= 32'(n_eff) * 32'(n_eff - 16'd1);
    end
    if (state == ST_SUB) begin
      lim <= LIM_W'(thr_sq) * LIM_W'(nn);
    end
    if (state == ST_CHECK) begin
      div_cnt <= '0;
    end else if (state == ST_DIV) begin
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!push) begin
        m_tvalid <= 1'b0;
      end
    end else if (!m_tvalid) begin
      if (push) m_tvalid <= 1'b1;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (push) begin
        out_res <= res;
      end
    end else if (!m_tvalid) begin
      if (push) out_res <= res;
    end else if (push) begin
      skid_res <= res;
    end
  end

  assign m_tdata = {out_res.bias[2], out_res.bias[1], out_res.bias[0],
                    out_res.rate[2], out_res.rate[1], out_res.rate[0]};
  assign m_tuser = {out_res.restarted, out_res.calibrating};

endmodule

### tb/sv/tb_gyro_bias_calibration_still_check_top.sv
// ----------------------------------------------------------------------------
// tb_gyro_bias_calibration_still_check_top
// Self-checking bench for the gyro bias calibration block. A scoreboard
// predicts every output transfer from the accepted samples and the register
// writes, and compares it field by field. Stimulus covers directed corner
// cases, one long run near full scale without idling, and random still,
// moving, broken and free-running sample sequences under several register
// settings.
// ----------------------------------------------------------------------------
module tb_gyro_bias_calibration_still_check_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gbc_pkg::*;

  localparam int RUN_END_GAP  = 48;
  localparam int RANDOM_ITEMS = 420;
  localparam int STEADY_LEN   = 64;

  typedef struct packed {
    gbc_word_t [2:0] rate;
    gbc_word_t [2:0] bias;
    logic            calibrating;
    logic            restarted;
  } rate_bias_t;

  class gyro_cal_scoreboard;
    logic [15:0]   cal_len;
    logic [9:0]    still_thr;
    logic [15:0]   left_cnt;
    longint        ax_sum[3];
    longint        ax_sq[3];
    gbc_word_t     bias[3];
    rate_bias_t    pending_results[$];
    int            mismatches;
    int            result_cnt;

    function new();
      cal_len    = LEN_RESET;
      still_thr  = THR_RESET;
      left_cnt   = '0;
      mismatches = 0;
      result_cnt = 0;
      clear_sums();
      foreach (bias[a]) bias[a] = '0;
    endfunction

    function void clear_sums();
      foreach (ax_sum[a]) begin
        ax_sum[a] = 0;
        ax_sq[a]  = 0;
      end
    endfunction

    function gbc_word_t clip16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return gbc_word_t'(v[15:0]);
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function void write_reg(gbc_reg_t idx, logic [15:0] val);
      case (idx)
        REG_LEN: cal_len = val;
        REG_THR: still_thr = val[9:0];
        default: ;
      endcase
    endfunction

    // predict the output transfer caused by one accepted sample
    function void note_sample(bit start, logic [47:0] data);
      gbc_word_t  smp[3];
      longint     n;
      longint     thr_sq;
      longint     lim;
      longint     spread;
      bit         cal;
      bit         moved;
      rate_bias_t r;
      r   = '0;
      cal = 1'b0;
      n   = (cal_len == 16'd0) ? 64'sd1 : longint'(cal_len);
      foreach (smp[a]) smp[a] = data[16*a +: 16];
      if (start) begin
        left_cnt = n[15:0];
        clear_sums();
      end
      if (left_cnt != 16'd0) begin
        cal = 1'b1;
        foreach (smp[a]) begin
          ax_sum[a] += longint'(smp[a]);
          ax_sq[a]  += longint'(smp[a]) * longint'(smp[a]);
          bias[a]    = '0;
        end
        if (left_cnt == 16'd1) begin
          moved = 1'b0;
          if (still_thr != '0) begin
            thr_sq = longint'(still_thr) * longint'(still_thr);
            lim    = thr_sq * n * (n - 1);
            foreach (smp[a]) begin
              spread = n * ax_sq[a] - ax_sum[a] * ax_sum[a];
              if (spread > lim) moved = 1'b1;
            end
          end
          if (moved) begin
            clear_sums();
            left_cnt    = n[15:0];
            r.restarted = 1'b1;
          end else begin
            foreach (bias[a]) bias[a] = clip16((ax_sum[a] + n / 2) / n);
            left_cnt = '0;
          end
        end else begin
          left_cnt--;
        end
      end
      for (int a = 0; a < 3; a++) begin
        r.rate[a] = cal ? 16'sd0 : clip16(longint'(smp[a]) - longint'(bias[a]));
        r.bias[a] = bias[a];
      end
      r.calibrating = cal;
      pending_results.push_back(r);
    endfunction

    function void flag(string what, longint want, longint got);
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s mismatch, expected %0d, got %0d",
                 result_cnt, what, want, got);
    endfunction

    function void check_result(logic [95:0] data, logic [1:0] user);
      rate_bias_t got;
      rate_bias_t want;
      for (int a = 0; a < 3; a++) begin
        got.rate[a] = data[16*a +: 16];
        got.bias[a] = data[48 + 16*a +: 16];
      end
      got.calibrating = user[0];
      got.restarted   = user[1];
      result_cnt++;
      if (pending_results.size() == 0) begin
        flag("unexpected transfer", 0, 1);
        return;
      end
      want = pending_results.pop_front();
      for (int a = 0; a < 3; a++) begin
        if (got.rate[a] !== want.rate[a])
          flag($sformatf("rate[%0d]", a), want.rate[a], got.rate[a]);
        if (got.bias[a] !== want.bias[a])
          flag($sformatf("bias[%0d]", a), want.bias[a], got.bias[a]);
      end
      if (got.calibrating !== want.calibrating)
        flag("calibrating", want.calibrating, got.calibrating);
      if (got.restarted !== want.restarted)
        flag("restarted", want.restarted, got.restarted);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  gyro_cal_scoreboard sb;
  bit                 steady = 1'b0;
  int                 samples_sent = 0;
  logic [15:0]        cur_len = LEN_RESET;
  logic [15:0]        cur_thr = 16'(THR_RESET);

  gyro_bias_calibration_still_check_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(0, 99) >= 23);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_sample(s_tuser[0], s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end
  end

  task automatic send_sample(input bit start, input int x, input int y, input int z);
    while (!steady && $urandom_range(0, 99) < 23) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= start;
    s_tdata  <= {16'(z), 16'(y), 16'(x)};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    samples_sent++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (RUN_END_GAP) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [15:0] len, input logic [15:0] thr);
    cfg_valid <= 1'b1;
    cfg_index <= REG_LEN;
    cfg_data  <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(REG_LEN, len);
    cfg_index <= REG_THR;
    cfg_data  <= thr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(REG_THR, thr);
    cfg_valid <= 1'b0;
    cur_len = len;
    cur_thr = thr;
  endtask

  // first sample carries the start flag; amp of 65535 means full-range noise
  task automatic send_run(input int count, input int amp);
    int base[3];
    int v[3];
    foreach (base[a]) base[a] = int'($urandom_range(0, 58000)) - 29000;
    for (int i = 0; i < count; i++) begin
      foreach (v[a]) begin
        if (amp >= 65535) v[a] = int'($urandom_range(0, 65535));
        else v[a] = base[a] + int'($urandom_range(0, 2 * amp)) - amp;
      end
      send_sample(i == 0, v[0], v[1], v[2]);
    end
  endtask

  task automatic send_free(input int count);
    for (int i = 0; i < count; i++)
      send_sample(1'b0, $urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535));
  endtask

  initial begin
    int random_start;
    int eff_n;
    int thr_eff;
    int amp;
    int kind;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // no run yet: rates follow the samples
    send_sample(1'b0, -32768, 32767, 0);
    send_sample(1'b0, 32767, -32768, -1);
    drain_results();

    // check disabled, two-sample run, then saturated rates
    write_cfg(16'd2, 16'd0);
    send_sample(1'b1, 20000, -20000, 0);
    send_sample(1'b0, 20001, -20001, 1);
    send_sample(1'b0, -32768, 32767, 32767);
    send_sample(1'b0, 5, -5, -32768);
    drain_results();

    // moving run restarts, still run passes, start during a run
    write_cfg(16'd3, 16'd1);
    send_sample(1'b1, 0, 0, 0);
    send_sample(1'b0, 1000, 0, 0);
    send_sample(1'b0, -1000, 0, 0);
    send_sample(1'b0, 7, 7, 7);
    send_sample(1'b0, 7, 7, 7);
    send_sample(1'b0, 7, 7, 7);
    send_sample(1'b1, 1, 2, 3);
    send_sample(1'b1, 4, 5, 6);
    send_sample(1'b0, 4, 5, 6);
    send_sample(1'b0, 4, 5, 6);
    drain_results();

    // length one and length zero
    write_cfg(16'd1, 16'hffff);
    send_sample(1'b1, -32768, 32767, 123);
    drain_results();
    write_cfg(16'd0, 16'd5);
    send_sample(1'b1, -3, -3, -3);
    send_sample(1'b0, 9, 9, 9);
    drain_results();

    // length shortened mid-run: bias saturates
    write_cfg(16'd10, 16'd5);
    send_sample(1'b1, 30000, -30000, 100);
    send_sample(1'b0, 30000, -30000, 100);
    drain_results();
    write_cfg(16'd2, 16'd5);
    repeat (8) send_sample(1'b0, 30000, -30000, 100);
    drain_results();

    // long run near full scale, no idling on either side
    write_cfg(16'(STEADY_LEN), 16'd1023);
    steady = 1'b1;
    for (int i = 0; i < STEADY_LEN; i++)
      send_sample(i == 0, -32768 + int'($urandom_range(0, 200)),
                  32767 - int'($urandom_range(0, 200)), $urandom_range(0, 1));
    send_free(3);
    drain_results();
    steady = 1'b0;

    random_start = samples_sent;
    while (samples_sent - random_start < RANDOM_ITEMS) begin
      drain_results();
      case ($urandom_range(0, 7))
        0:       cur_len = 16'd2;
        1:       cur_len = 16'd0;
        2:       cur_len = 16'd1;
        3:       cur_len = 16'd3;
        default: cur_len = 16'($urandom_range(2, 24));
      endcase
      case ($urandom_range(0, 5))
        0:       cur_thr = 16'd0;
        1:       cur_thr = 16'd1023;
        2:       cur_thr = 16'd1;
        3:       cur_thr = 16'($urandom_range(0, 65535));
        default: cur_thr = 16'($urandom_range(2, 64));
      endcase
      write_cfg(cur_len, cur_thr);
      eff_n   = (cur_len == 16'd0) ? 1 : int'(cur_len);
      thr_eff = int'(cur_thr[9:0]);
      repeat ($urandom_range(3, 6)) begin
        case ($urandom_range(0, 3))
          0:       amp = 0;
          1:       amp = thr_eff / 2;
          2:       amp = 3 * thr_eff + 1;
          default: amp = 65535;
        endcase
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
          send_run(eff_n, amp);
          send_free($urandom_range(0, 3));
        end else if (kind < 8) begin
          send_free($urandom_range(3, 8));
        end else begin
          send_run($urandom_range(1, eff_n), amp);
          send_run(eff_n, amp);
        end
        if ($urandom_range(0, 9) == 0) drain_results();
      end
    end

    drain_results();
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### files.f
src/gbc_pkg.sv
src/gbc_lane.sv
src/gbc_merge.sv
src/gyro_bias_calibration_still_check_top.sv
tb/sv/tb_gyro_bias_calibration_still_check_top.sv
